FILE: rtl/mbe_pkg.sv
`timescale 1ns / 1ps
package mbe_pkg;

	localparam int TBL_DEPTH = 48;
	localparam int IDX_W = 6;

	typedef logic signed [63:0] q_t;
	typedef logic [63:0] turn_t;
	typedef turn_t atan_tbl_t [TBL_DEPTH];

	localparam q_t QMAX = 64'sd140737488355327;
	localparam q_t INV_GAIN = 64'sd667681663043;
	localparam q_t TWO_Q = 64'sh0000_0200_0000_0000;
	localparam turn_t HALF_TURN = 64'h8000_0000_0000_0000;
	localparam turn_t QUARTER_TURN = 64'h4000_0000_0000_0000;
	localparam turn_t INV_TWO_PI = 64'h28BE_60DB_9391_054A;

	typedef enum logic {
		CM_VEC = 1'b0,
		CM_ROT = 1'b1
	} cordic_mode_t;

	typedef struct packed {
		logic         start;
		cordic_mode_t mode;
	} cordic_cmd_t;

	// restoring division, elaboration only
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int j = 63; j >= 0; j--) begin
			rem = {rem[63:0], num[j]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[j] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic turn_t atan_entry(input int i);
		logic [63:0] acc;
		logic [63:0] term;
		logic [127:0] prod;
		int e;
		acc = '0;
		if (i == 0) begin
			return 64'h2000_0000_0000_0000;
		end
		for (int k = 0; k < 64; k++) begin
			e = i * (2 * k + 1);
			if (e < 64) begin
				term = udiv64(64'd1 << (64 - e), 64'(2 * k + 1));
				if (k % 2 == 1) begin
					acc = acc - term;
				end else begin
					acc = acc + term;
				end
			end
		end
		prod = {64'd0, acc} * {64'd0, INV_TWO_PI};
		return prod[127:64];
	endfunction

	function automatic atan_tbl_t build_atan();
		atan_tbl_t t;
		for (int i = 0; i < TBL_DEPTH; i++) begin
			t[i] = atan_entry(i);
		end
		return t;
	endfunction

	localparam atan_tbl_t ATAN_TBL = build_atan();

	function automatic q_t sat_q(input q_t v);
		if (v > QMAX) begin
			return QMAX;
		end
		if (v < -QMAX) begin
			return -QMAX;
		end
		return v;
	endfunction

endpackage

FILE: rtl/mbe_mul.sv
`timescale 1ns / 1ps
module mbe_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  mbe_pkg::q_t a,
	input  mbe_pkg::q_t b,
	output mbe_pkg::q_t p,
	output logic        done
);

	logic [63:0]  ma_q, mb_q;
	logic         neg_q;
	logic [127:0] acc_q;
	logic [1:0]   cnt_q;
	logic         run_q, fin_q, done_q;
	mbe_pkg::q_t  p_q;
	logic [63:0]  pp;
	logic [127:0] pp_sh;
	logic [46:0]  mag;

	assign pp = {32'd0, ma_q[cnt_q[1]*32 +: 32]} * {32'd0, mb_q[cnt_q[0]*32 +: 32]};

	always_comb begin
		case ({1'b0, cnt_q[1]} + {1'b0, cnt_q[0]})
			2'd0:    pp_sh = {64'd0, pp};
			2'd1:    pp_sh = {32'd0, pp, 32'd0};
			2'd2:    pp_sh = {pp, 64'd0};
			default: pp_sh = '0;
		endcase
	end

	assign mag = (acc_q[127:87] != '0) ? mbe_pkg::QMAX[46:0] : acc_q[86:40];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			fin_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
			if (fin_q) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q <= a[63] ? 64'(-a) : 64'(a);
			mb_q <= b[63] ? 64'(-b) : 64'(b);
			neg_q <= a[63] ^ b[63];
			acc_q <= '0;
		end else if (run_q) begin
			acc_q <= acc_q + pp_sh;
		end
		if (fin_q) begin
			p_q <= neg_q ? -$signed({17'd0, mag}) : $signed({17'd0, mag});
		end
	end

	assign p = p_q;
	assign done = done_q;

endmodule

FILE: rtl/mbe_cordic.sv
`timescale 1ns / 1ps
module mbe_cordic #(
	parameter int STEPS = 40
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mbe_pkg::cordic_cmd_t cmd,
	input  mbe_pkg::q_t         in_a,
	input  mbe_pkg::q_t         in_b,
	input  mbe_pkg::turn_t      in_ang,
	output mbe_pkg::q_t         out_a,
	output mbe_pkg::q_t         out_b,
	output mbe_pkg::turn_t      out_ang,
	output logic                done
);

	mbe_pkg::q_t          a_q, b_q, a_sh, b_sh;
	mbe_pkg::turn_t       ang_q, rot_ang, t;
	mbe_pkg::cordic_mode_t mode_q;
	logic                 neg_q, run_q, done_q;
	logic [mbe_pkg::IDX_W-1:0] cnt_q;

	assign a_sh = a_q >>> cnt_q;
	assign b_sh = b_q >>> cnt_q;
	assign t = mbe_pkg::ATAN_TBL[cnt_q];
	assign rot_ang = in_ang + mbe_pkg::QUARTER_TURN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == mbe_pkg::IDX_W'(STEPS - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mode_q <= cmd.mode;
			if (cmd.mode == mbe_pkg::CM_VEC) begin
				neg_q <= 1'b0;
				if (in_a[63]) begin
					a_q <= -in_a;
					b_q <= -in_b;
					ang_q <= mbe_pkg::HALF_TURN;
				end else begin
					a_q <= in_a;
					b_q <= in_b;
					ang_q <= '0;
				end
			end else begin
				a_q <= mbe_pkg::INV_GAIN;
				b_q <= '0;
				neg_q <= rot_ang[63];
				ang_q <= rot_ang[63] ? in_ang + mbe_pkg::HALF_TURN : in_ang;
			end
		end else if (run_q) begin
			if (mode_q == mbe_pkg::CM_VEC) begin
				if (!b_q[63]) begin
					a_q <= a_q + b_sh;
					b_q <= b_q - a_sh;
					ang_q <= ang_q + t;
				end else begin
					a_q <= a_q - b_sh;
					b_q <= b_q + a_sh;
					ang_q <= ang_q - t;
				end
			end else begin
				if (!ang_q[63]) begin
					a_q <= a_q - b_sh;
					b_q <= b_q + a_sh;
					ang_q <= ang_q - t;
				end else begin
					a_q <= a_q + b_sh;
					b_q <= b_q - a_sh;
					ang_q <= ang_q + t;
				end
			end
		end
	end

	assign out_a = neg_q ? -a_q : a_q;
	assign out_b = neg_q ? -b_q : b_q;
	assign out_ang = ang_q;
	assign done = done_q;

endmodule

FILE: rtl/mandelbulb_escape_time.sv
`timescale 1ns / 1ps
// channel | signals                          | beat taken when
// in      | start, point_x/y/z, busy         | start && !busy
// out     | done, shade, escaped, escape_pass| done (one cycle, no stall)
// One CORDIC unit (one micro-rotation per cycle) and one multiplier (four
// 32x32 partial products summed per product) are shared by all steps.
// A pass is 4 CORDIC runs and 12 products; an item takes up to
// (MAX_PASS+1) passes.
// busy is high while the sequencer is out of idle; it is low when done is shown.
// Reset clears the sequencer; no clearing pass. The receiver cannot stall.
module mandelbulb_escape_time #(
	parameter int MAX_PASS = 32,
	parameter int CORDIC_STEPS = 40
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	output logic               done,
	output logic [8:0]         shade,
	output logic               escaped,
	output logic [5:0]         escape_pass
);

	typedef enum logic [17:0] {
		S_IDLE  = 18'h00001,
		S_VXY   = 18'h00002,
		S_GRHO  = 18'h00004,
		S_VZR   = 18'h00008,
		S_GR    = 18'h00010,
		S_SQ1   = 18'h00020,
		S_SQ2   = 18'h00040,
		S_SQ3   = 18'h00080,
		S_ROTT  = 18'h00100,
		S_ROTP  = 18'h00200,
		S_AMP   = 18'h00400,
		S_MX    = 18'h00800,
		S_MY    = 18'h01000,
		S_MZ    = 18'h02000,
		S_XX    = 18'h04000,
		S_YY    = 18'h08000,
		S_ZZ    = 18'h10000
	} state_t;

	state_t state_q;
	logic   go_q;
	mbe_pkg::q_t cx_q, cy_q, cz_q, x_q, y_q, z_q;
	mbe_pkg::q_t rho_q, r_q, ct_q, st_q, cp_q, sp_q, amp_q, sum_q;
	mbe_pkg::turn_t phi_q, theta_q;
	logic [5:0] pass_q;
	logic       done_q, esc_q;
	logic [8:0] shade_q;
	logic [5:0] epass_q;

	mbe_pkg::cordic_cmd_t cmd;
	mbe_pkg::q_t   c_a, c_b, c_oa, c_ob;
	mbe_pkg::turn_t c_ang, c_oang;
	logic          c_done;
	logic          m_start, m_done;
	mbe_pkg::q_t   m_a, m_b, m_p;
	mbe_pkg::q_t   sum_all;

	always_comb begin
		cmd.start = 1'b0;
		cmd.mode = mbe_pkg::CM_VEC;
		c_a = x_q;
		c_b = y_q;
		c_ang = theta_q << 3;
		m_start = 1'b0;
		m_a = c_oa;
		m_b = mbe_pkg::INV_GAIN;
		case (state_q)
			S_VXY: begin
				cmd.start = go_q;
			end
			S_VZR: begin
				cmd.start = go_q;
				c_a = z_q;
				c_b = rho_q;
			end
			S_ROTT: begin
				cmd.start = go_q;
				cmd.mode = mbe_pkg::CM_ROT;
			end
			S_ROTP: begin
				cmd.start = go_q;
				cmd.mode = mbe_pkg::CM_ROT;
				c_ang = phi_q << 3;
			end
			S_GRHO, S_GR: begin
				m_start = go_q;
			end
			S_SQ1, S_SQ2, S_SQ3: begin
				m_start = go_q;
				m_a = r_q;
				m_b = r_q;
			end
			S_AMP: begin
				m_start = go_q;
				m_a = r_q;
				m_b = st_q;
			end
			S_MX: begin
				m_start = go_q;
				m_a = amp_q;
				m_b = cp_q;
			end
			S_MY: begin
				m_start = go_q;
				m_a = amp_q;
				m_b = sp_q;
			end
			S_MZ: begin
				m_start = go_q;
				m_a = r_q;
				m_b = ct_q;
			end
			S_XX: begin
				m_start = go_q;
				m_a = x_q;
				m_b = x_q;
			end
			S_YY: begin
				m_start = go_q;
				m_a = y_q;
				m_b = y_q;
			end
			S_ZZ: begin
				m_start = go_q;
				m_a = z_q;
				m_b = z_q;
			end
			default: begin
			end
		endcase
	end

	mbe_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_a    (c_a),
		.in_b    (c_b),
		.in_ang  (c_ang),
		.out_a   (c_oa),
		.out_b   (c_ob),
		.out_ang (c_oang),
		.done    (c_done)
	);

	mbe_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (m_start),
		.a      (m_a),
		.b      (m_b),
		.p      (m_p),
		.done   (m_done)
	);

	assign sum_all = sum_q + m_p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			go_q <= 1'b0;
			done_q <= 1'b0;
			pass_q <= '0;
		end else begin
			done_q <= 1'b0;
			go_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_VXY;
						go_q <= 1'b1;
						pass_q <= '0;
					end
				end
				S_VXY: if (c_done) begin state_q <= S_GRHO; go_q <= 1'b1; end
				S_GRHO: if (m_done) begin state_q <= S_VZR; go_q <= 1'b1; end
				S_VZR: if (c_done) begin state_q <= S_GR; go_q <= 1'b1; end
				S_GR: if (m_done) begin state_q <= S_SQ1; go_q <= 1'b1; end
				S_SQ1: if (m_done) begin state_q <= S_SQ2; go_q <= 1'b1; end
				S_SQ2: if (m_done) begin state_q <= S_SQ3; go_q <= 1'b1; end
				S_SQ3: if (m_done) begin state_q <= S_ROTT; go_q <= 1'b1; end
				S_ROTT: if (c_done) begin state_q <= S_ROTP; go_q <= 1'b1; end
				S_ROTP: if (c_done) begin state_q <= S_AMP; go_q <= 1'b1; end
				S_AMP: if (m_done) begin state_q <= S_MX; go_q <= 1'b1; end
				S_MX: if (m_done) begin state_q <= S_MY; go_q <= 1'b1; end
				S_MY: if (m_done) begin state_q <= S_MZ; go_q <= 1'b1; end
				S_MZ: if (m_done) begin state_q <= S_XX; go_q <= 1'b1; end
				S_XX: if (m_done) begin state_q <= S_YY; go_q <= 1'b1; end
				S_YY: if (m_done) begin state_q <= S_ZZ; go_q <= 1'b1; end
				S_ZZ: begin
					if (m_done) begin
						if (sum_all > mbe_pkg::TWO_Q || pass_q == 6'(MAX_PASS)) begin
							state_q <= S_IDLE;
							done_q <= 1'b1;
						end else begin
							state_q <= S_VXY;
							go_q <= 1'b1;
							pass_q <= pass_q + 6'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cx_q <= 64'(point_x) <<< 12;
					cy_q <= 64'(point_y) <<< 12;
					cz_q <= 64'(point_z) <<< 12;
					x_q <= '0;
					y_q <= '0;
					z_q <= '0;
				end
			end
			S_VXY: if (c_done) phi_q <= c_oang;
			S_GRHO: if (m_done) rho_q <= m_p;
			S_VZR: if (c_done) theta_q <= c_oang;
			S_GR, S_SQ1, S_SQ2, S_SQ3: if (m_done) r_q <= m_p;
			S_ROTT: begin
				if (c_done) begin
					ct_q <= c_oa;
					st_q <= c_ob;
				end
			end
			S_ROTP: begin
				if (c_done) begin
					cp_q <= c_oa;
					sp_q <= c_ob;
				end
			end
			S_AMP: if (m_done) amp_q <= m_p;
			S_MX: if (m_done) x_q <= mbe_pkg::sat_q(m_p + cx_q);
			S_MY: if (m_done) y_q <= mbe_pkg::sat_q(m_p + cy_q);
			S_MZ: if (m_done) z_q <= mbe_pkg::sat_q(m_p + cz_q);
			S_XX: if (m_done) sum_q <= m_p;
			S_YY: if (m_done) sum_q <= sum_all;
			S_ZZ: begin
				if (m_done) begin
					if (sum_all > mbe_pkg::TWO_Q) begin
						esc_q <= 1'b1;
						epass_q <= pass_q;
						shade_q <= 9'd256 - {1'b0, pass_q, 2'b00};
					end else begin
						esc_q <= 1'b0;
						epass_q <= '0;
						shade_q <= '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign shade = shade_q;
	assign escaped = esc_q;
	assign escape_pass = epass_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("start not taken");
	a_no_esc: assert property (@(posedge clk) disable iff (!arst_n)
		done && !escaped |-> shade == 9'd0 && escape_pass == 6'd0)
		else $error("bad no-escape result");
	a_shade: assert property (@(posedge clk) disable iff (!arst_n)
		done && escaped |-> shade == 9'd256 - {1'b0, escape_pass, 2'b00})
		else $error("shade mismatch");

endmodule
